// File: hdl/psc_pkg.sv
// Shared constants, types and helper functions of the pair syndrome cover counter.
`default_nettype none
package psc_pkg;

	localparam int MAX_COLUMNS    = 256;
	localparam int MAX_REDUNDANCY = 12;
	localparam int MIN_REDUNDANCY = 3;

	localparam int SYN_W       = MAX_REDUNDANCY;
	localparam int TABLE_DEPTH = 1 << SYN_W;
	localparam int SLOT_W      = $clog2(MAX_COLUMNS);
	localparam int LOAD_W      = $clog2(MAX_COLUMNS + 1);
	localparam int CNT_W       = 8;
	localparam int WORD_W      = CNT_W + 1;

	localparam int OP_W       = 2;
	localparam int COL_W      = 12;
	localparam int UNC_W      = 12;
	localparam int RED_W      = 4;
	localparam int TOTAL_W    = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_SWAP   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REDUNDANCY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TOTAL = 1'd1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// One count update for the shared read-modify-write unit.
	typedef struct packed {
		logic valid;
		logic up;
		logic self_hit;
	} psc_bump_t;

	// Reload of the uncovered total during a clearing pass.
	typedef struct packed {
		logic             load;
		logic [SYN_W-1:0] value;
	} psc_init_t;

	function automatic logic [RED_W-1:0] clamp_red(input logic [RED_W-1:0] r);
		logic [RED_W-1:0] res;
		res = r;
		if (r < RED_W'(MIN_REDUNDANCY))
			res = RED_W'(MIN_REDUNDANCY);
		else if (r > RED_W'(MAX_REDUNDANCY))
			res = RED_W'(MAX_REDUNDANCY);
		return res;
	endfunction

	// Space size minus one for a clamped redundancy.
	function automatic logic [SYN_W-1:0] space_last(input logic [RED_W-1:0] r);
		logic [SYN_W-1:0] ones;
		ones = '1;
		return ones >> (RED_W'(MAX_REDUNDANCY) - r);
	endfunction

endpackage
`default_nettype wire

// File: hdl/psc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module psc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/psc_update.sv
// Shared count update unit: increments or decrements one cover count and tracks the uncovered total.
`default_nettype none
module psc_update (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire psc_pkg::psc_init_t          init,
	input  wire psc_pkg::psc_bump_t          bump,
	input  wire logic [psc_pkg::WORD_W-1:0]  rdata,
	output logic                             we,
	output logic      [psc_pkg::WORD_W-1:0]  wdata,
	output logic      [psc_pkg::SYN_W-1:0]   uncovered
);
	import psc_pkg::*;

	logic [CNT_W-1:0] count;
	logic             mark;
	logic [CNT_W-1:0] count_new;
	logic             mark_new;
	logic [SYN_W-1:0] uncovered_q;

	assign count = rdata[CNT_W-1:0];
	assign mark  = rdata[CNT_W];

	always_comb begin
		count_new = bump.up ? count + CNT_W'(1) : count - CNT_W'(1);
		// the column's own entry carries its in-use mark
		mark_new  = bump.self_hit ? bump.up : mark;
	end

	assign we        = bump.valid;
	assign wdata     = {mark_new, count_new};
	assign uncovered = uncovered_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uncovered_q <= '0;
		end else if (init.load) begin
			uncovered_q <= init.value;
		end else if (bump.valid) begin
			if (bump.up && count == '0)
				uncovered_q <= uncovered_q - SYN_W'(1);
			else if (!bump.up && count == CNT_W'(1))
				uncovered_q <= uncovered_q + SYN_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: hdl/pair_syndrome_cover_counter_unit.sv
// Top level of the pair syndrome cover counter: sequencer, column store and count table.
//
// Input channel (in_valid/in_ready) carries opcode, slot and column; the output channel
// (out_valid/out_ready) returns one result per transaction: uncovered count and status.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes redundancy (index 0)
// or column_total (index 1). A redundancy write starts a clearing pass.
// Operations:
//   clear:  one count table entry written per cycle
//   append: one count update per cycle through the update pipeline
//   swap:   a withdraw pass and an add pass, drained in between
// The count table read-modify-write unit handles one syndrome per cycle; the table has
// one read and one write port, which sets this rate. One transaction at a time.
// Reset: a clearing pass of the whole count table runs with in_ready low;
// configuration writes are taken meanwhile. No result is produced for it.
// The result sits in an output register; a new transaction may be accepted while it
// waits. If the receiver stalls, the next result waits until the register is free.
`default_nettype none
module pair_syndrome_cover_counter_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [psc_pkg::OP_W-1:0]         opcode,
	input  wire logic [psc_pkg::SLOT_W-1:0]       slot,
	input  wire logic [psc_pkg::COL_W-1:0]        column,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [psc_pkg::UNC_W-1:0]        uncovered,
	output logic                                  status,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import psc_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_DECIDE,
		S_PASS,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [SYN_W-1:0]   clr_cnt_q;
	logic               clr_reply_q;
	logic [OP_W-1:0]    op_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [COL_W-1:0]   col_q;
	logic [RED_W-1:0]   redundancy_q;
	logic [TOTAL_W-1:0] column_total_q;
	logic [LOAD_W-1:0]  loaded_q;
	logic [LOAD_W-1:0]  k_q;
	logic [SYN_W-1:0]   base_q;
	logic               up_q;
	logic               skip_en_q;
	logic               second_q;
	logic               status_q;
	logic               v_s1_q;
	logic               self_s1_q;
	logic               v_s2_q;
	logic               self_s2_q;
	logic [SYN_W-1:0]   addr_s2_q;
	logic               out_valid_q;
	logic [UNC_W-1:0]   res_uncovered_q;
	logic               res_status_q;

	logic [RED_W-1:0]   red_eff;
	logic [SYN_W-1:0]   col_sy;
	logic [LOAD_W-1:0]  capacity;
	logic               col_ok;
	logic               slot_in;
	logic               drained;
	logic [SLOT_W-1:0]  pass_addr;
	logic               issue_valid;
	logic [SYN_W-1:0]   syndrome_s1;

	logic               store_we;
	logic [SLOT_W-1:0]  store_waddr;
	logic [SLOT_W-1:0]  store_raddr;
	logic [SYN_W-1:0]   store_rdata;

	logic               count_we;
	logic [SYN_W-1:0]   count_waddr;
	logic [WORD_W-1:0]  count_wdata;
	logic [SYN_W-1:0]   count_raddr;
	logic [WORD_W-1:0]  count_rdata;

	psc_bump_t          bump;
	psc_init_t          init;
	logic               upd_we;
	logic [WORD_W-1:0]  upd_wdata;
	logic [SYN_W-1:0]   unc_total;

	assign red_eff  = clamp_red(redundancy_q);
	assign col_sy   = SYN_W'(col_q);
	assign capacity = (LOAD_W'(column_total_q) > LOAD_W'(MAX_COLUMNS)) ?
		LOAD_W'(MAX_COLUMNS) : LOAD_W'(column_total_q);
	// the mark of the column arrives from the count table in S_DECIDE
	assign col_ok   = (col_q != '0) && ((col_q >> red_eff) == '0) && !count_rdata[CNT_W];
	assign slot_in  = LOAD_W'(slot_q) < loaded_q;
	assign drained  = !v_s1_q && !v_s2_q;

	assign pass_addr   = SLOT_W'(k_q - LOAD_W'(1));
	assign issue_valid = !(skip_en_q && (k_q != '0) && (pass_addr == slot_q));
	assign syndrome_s1 = self_s1_q ? base_q : (base_q ^ store_rdata);

	always_comb begin
		store_raddr = (state_q == S_CHECK) ? slot_q : pass_addr;
		count_raddr = (state_q == S_CHECK) ? col_sy : syndrome_s1;

		store_we    = (state_q == S_DRAIN) && drained && !second_q;
		store_waddr = (op_q == OP_APPEND) ? loaded_q[SLOT_W-1:0] : slot_q;

		bump.valid    = v_s2_q;
		bump.up       = up_q;
		bump.self_hit = self_s2_q;
		init.load     = (state_q == S_CLEAR);
		init.value    = space_last(red_eff);

		if (state_q == S_CLEAR) begin
			count_we    = 1'b1;
			count_waddr = clr_cnt_q;
			count_wdata = '0;
		end else begin
			count_we    = upd_we;
			count_waddr = addr_s2_q;
			count_wdata = upd_wdata;
		end
	end

	psc_ram #(
		.WIDTH(SYN_W),
		.DEPTH(MAX_COLUMNS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (col_sy),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	psc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_counts (
		.clk   (clk),
		.we    (count_we),
		.waddr (count_waddr),
		.wdata (count_wdata),
		.raddr (count_raddr),
		.rdata (count_rdata)
	);

	psc_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (init),
		.bump      (bump),
		.rdata     (count_rdata),
		.we        (upd_we),
		.wdata     (upd_wdata),
		.uncovered (unc_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_cnt_q       <= '0;
			clr_reply_q     <= 1'b0;
			op_q            <= OP_CLEAR;
			slot_q          <= '0;
			col_q           <= '0;
			redundancy_q    <= RED_W'(11);
			column_total_q  <= TOTAL_W'(78);
			loaded_q        <= '0;
			k_q             <= '0;
			base_q          <= '0;
			up_q            <= 1'b0;
			skip_en_q       <= 1'b0;
			second_q        <= 1'b0;
			status_q        <= STATUS_OK;
			v_s1_q          <= 1'b0;
			self_s1_q       <= 1'b0;
			v_s2_q          <= 1'b0;
			self_s2_q       <= 1'b0;
			addr_s2_q       <= '0;
			out_valid_q     <= 1'b0;
			res_uncovered_q <= '0;
			res_status_q    <= STATUS_OK;
		end else begin
			v_s1_q    <= 1'b0;
			v_s2_q    <= v_s1_q;
			self_s2_q <= self_s1_q;
			addr_s2_q <= syndrome_s1;

			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					loaded_q  <= '0;
					clr_cnt_q <= clr_cnt_q + SYN_W'(1);
					if (clr_cnt_q == '1) begin
						if (clr_reply_q) begin
							clr_reply_q <= 1'b0;
							status_q    <= STATUS_OK;
							state_q     <= S_FINISH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						slot_q  <= slot;
						col_q   <= column;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					k_q      <= '0;
					status_q <= STATUS_REJECT;
					state_q  <= S_FINISH;
					case (op_q)
						OP_CLEAR: begin
							clr_reply_q <= 1'b1;
							clr_cnt_q   <= '0;
							status_q    <= STATUS_OK;
							state_q     <= S_CLEAR;
						end
						OP_APPEND: begin
							if (col_ok && loaded_q < capacity) begin
								base_q    <= col_sy;
								up_q      <= 1'b1;
								skip_en_q <= 1'b0;
								second_q  <= 1'b0;
								status_q  <= STATUS_OK;
								state_q   <= S_PASS;
							end
						end
						OP_SWAP: begin
							if (col_ok && slot_in) begin
								// withdraw the old column first
								base_q    <= store_rdata;
								up_q      <= 1'b0;
								skip_en_q <= 1'b1;
								second_q  <= 1'b1;
								status_q  <= STATUS_OK;
								state_q   <= S_PASS;
							end
						end
						default: ;
					endcase
				end
				S_PASS: begin
					v_s1_q    <= issue_valid;
					self_s1_q <= (k_q == '0);
					k_q       <= k_q + LOAD_W'(1);
					if (k_q == loaded_q)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (drained) begin
						if (second_q) begin
							// add the new column once the withdraw pass has settled
							second_q <= 1'b0;
							base_q   <= col_sy;
							up_q     <= 1'b1;
							k_q      <= '0;
							state_q  <= S_PASS;
						end else begin
							if (op_q == OP_APPEND)
								loaded_q <= loaded_q + LOAD_W'(1);
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q     <= 1'b1;
						res_uncovered_q <= UNC_W'(unc_total);
						res_status_q    <= status_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_valid) begin
				case (cfg_index)
					REG_REDUNDANCY: begin
						redundancy_q <= cfg_data[RED_W-1:0];
						clr_cnt_q    <= '0;
						state_q      <= S_CLEAR;
					end
					REG_COLUMN_TOTAL: column_total_q <= cfg_data[TOTAL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign uncovered = res_uncovered_q;
	assign status    = res_status_q;

endmodule
`default_nettype wire

// File: hdl/psc_checker.sv
// Port-level checker for the pair syndrome cover counter, bound to the top level.
`default_nettype none
module psc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [psc_pkg::UNC_W-1:0]        uncovered,
	input wire logic                             status,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready,
	input wire logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index
);
	import psc_pkg::*;

	// one transaction at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an accepted transaction");

	// a redundancy write starts a clearing pass
	a_clear_on_redundancy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_REDUNDANCY) |=> !in_ready)
		else $error("no clearing pass after redundancy write");

	// a new result frees the input side
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid) && !$past(cfg_valid)) |-> in_ready)
		else $error("input not ready when a result is presented");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(uncovered) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind pair_syndrome_cover_counter_unit psc_checker u_psc_checker (.*);
`default_nettype wire

// File: sim/pair_syndrome_cover_counter_unit_tb.sv
// Self-checking testbench of the pair syndrome cover counter with a predicting scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
	logic [psc_pkg::UNC_W-1:0] uncovered;
	logic                      status;
} cover_result_t;

// Tracks stored columns and syndrome cover counts; queues the result each transaction should give.
class syndrome_cover_tracker;
	logic [psc_pkg::RED_W-1:0]   red_bits;
	logic [psc_pkg::TOTAL_W-1:0] slot_limit;
	logic [psc_pkg::COL_W-1:0]   columns [psc_pkg::MAX_COLUMNS];
	int unsigned                 hits [psc_pkg::TABLE_DEPTH];
	bit                          taken [psc_pkg::TABLE_DEPTH];
	int unsigned                 zero_hits;
	int unsigned                 n_loaded;
	cover_result_t               due [$];
	int unsigned                 mismatches;

	function new();
		red_bits   = 4'd11;
		slot_limit = 9'd78;
		mismatches = 0;
		foreach (columns[i])
			columns[i] = '0;
		wipe();
	endfunction

	function int unsigned space_size();
		int unsigned r;
		r = red_bits;
		if (r < psc_pkg::MIN_REDUNDANCY)
			r = psc_pkg::MIN_REDUNDANCY;
		if (r > psc_pkg::MAX_REDUNDANCY)
			r = psc_pkg::MAX_REDUNDANCY;
		return 1 << r;
	endfunction

	function int unsigned capacity();
		return (slot_limit < psc_pkg::MAX_COLUMNS) ? slot_limit : psc_pkg::MAX_COLUMNS;
	endfunction

	function void wipe();
		foreach (hits[i]) begin
			hits[i]  = 0;
			taken[i] = 1'b0;
		end
		hits[0]   = 1;
		zero_hits = space_size() - 1;
		n_loaded  = 0;
	endfunction

	function void bump(int unsigned syn, bit up);
		int unsigned s;
		s = syn % psc_pkg::TABLE_DEPTH;
		if (up) begin
			if (hits[s] == 0)
				zero_hits--;
			hits[s]++;
		end else begin
			if (hits[s] == 1)
				zero_hits++;
			hits[s]--;
		end
	endfunction

	// Add or withdraw a column against itself and every stored column but the skipped slot.
	function void spread(logic [psc_pkg::COL_W-1:0] col, int unsigned skip, bit up);
		bump(col, up);
		for (int unsigned i = 0; i < n_loaded; i++) begin
			if (i != skip)
				bump(col ^ columns[i], up);
		end
	endfunction

	function void note_config(logic [psc_pkg::CFG_IDX_W-1:0] idx,
	                          logic [psc_pkg::CFG_DATA_W-1:0] data);
		if (idx == psc_pkg::REG_REDUNDANCY) begin
			red_bits = data[psc_pkg::RED_W-1:0];
			wipe();
		end else begin
			slot_limit = data[psc_pkg::TOTAL_W-1:0];
		end
	endfunction

	function void note_transaction(logic [psc_pkg::OP_W-1:0] op,
	                               logic [psc_pkg::SLOT_W-1:0] slot,
	                               logic [psc_pkg::COL_W-1:0] col);
		cover_result_t            res;
		bit                       col_ok;
		logic [psc_pkg::COL_W-1:0] removed;
		col_ok     = (col != 0) && (col < space_size()) && !taken[col];
		res.status = psc_pkg::STATUS_REJECT;
		case (op)
			psc_pkg::OP_CLEAR: begin
				wipe();
				res.status = psc_pkg::STATUS_OK;
			end
			psc_pkg::OP_APPEND: begin
				if (col_ok && n_loaded < capacity()) begin
					spread(col, psc_pkg::MAX_COLUMNS, 1'b1);
					columns[n_loaded] = col;
					taken[col]        = 1'b1;
					n_loaded++;
					res.status = psc_pkg::STATUS_OK;
				end
			end
			psc_pkg::OP_SWAP: begin
				if (col_ok && slot < n_loaded) begin
					removed = columns[slot];
					spread(removed, slot, 1'b0);
					spread(col, slot, 1'b1);
					taken[removed] = 1'b0;
					taken[col]     = 1'b1;
					columns[slot]  = col;
					res.status = psc_pkg::STATUS_OK;
				end
			end
			default: ;
		endcase
		res.uncovered = psc_pkg::UNC_W'(zero_hits);
		due.push_back(res);
	endfunction

	function void compare_result(logic [psc_pkg::UNC_W-1:0] unc, logic st);
		cover_result_t want;
		if (due.size() == 0) begin
			$display("%0t: result with none pending: uncovered %0d status %0d", $time, unc, st);
			mismatches++;
			return;
		end
		want = due.pop_front();
		if (want.uncovered !== unc) begin
			$display("%0t: uncovered expected %0d actual %0d", $time, want.uncovered, unc);
			mismatches++;
		end
		if (want.status !== st) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, st);
			mismatches++;
		end
	endfunction
endclass

module pair_syndrome_cover_counter_unit_tb;
	import psc_pkg::*;

	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
	localparam int GAP_PCT     = 18;
	localparam int TAIL_CYCLES = 64;

	logic                  clk       = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [OP_W-1:0]       opcode;
	logic [SLOT_W-1:0]     slot;
	logic [COL_W-1:0]      column;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [UNC_W-1:0]      uncovered;
	logic                  status;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    calm      = 1'b0;

	syndrome_cover_tracker syn_cover = new();

	pair_syndrome_cover_counter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.slot      (slot),
		.column    (column),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.uncovered (uncovered),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= GAP_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			syn_cover.compare_result(uncovered, status);
	end

	// Call at a falling edge; returns at the falling edge after the transaction is accepted.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sl,
	                         input logic [COL_W-1:0] col);
		while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		slot     <= sl;
		column   <= col;
		do @(posedge clk); while (!in_ready);
		syn_cover.note_transaction(op, sl, col);
		@(negedge clk);
	endtask

	// Hold the sender until every pending result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (syn_cover.due.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		syn_cover.note_config(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Upper data bits are junk; only the low four count.
	task automatic set_space(input int unsigned r);
		write_reg(REG_REDUNDANCY, CFG_DATA_W'(($urandom_range(0, 31) << 4) | r));
	endtask

	function automatic logic [COL_W-1:0] fresh_column();
		int unsigned c;
		do c = $urandom_range(1, syn_cover.space_size() - 1); while (syn_cover.taken[c]);
		return COL_W'(c);
	endfunction

	task automatic random_item(input int unsigned clear_pct);
		int unsigned       pick;
		int unsigned       space;
		int unsigned       ld;
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] sl;
		logic [COL_W-1:0]  col;
		space = syn_cover.space_size();
		ld    = syn_cover.n_loaded;
		op    = OP_APPEND;
		sl    = SLOT_W'($urandom);
		col   = COL_W'($urandom);
		pick  = $urandom_range(0, 99);
		if (pick < clear_pct) begin
			op = OP_CLEAR;
		end else if (pick < 88 && ld + 1 < space) begin
			col = fresh_column();
			if (ld < syn_cover.capacity() && (ld == 0 || $urandom_range(0, 99) < 55)) begin
				op = OP_APPEND;
			end else if (ld > 0) begin
				op = OP_SWAP;
				sl = SLOT_W'($urandom_range(0, ld - 1));
			end
		end else begin
			case ($urandom_range(0, 5))
				0: begin
					op  = $urandom_range(0, 1) ? OP_APPEND : OP_SWAP;
					col = '0;
				end
				1: begin
					op  = $urandom_range(0, 1) ? OP_APPEND : OP_SWAP;
					col = (space < TABLE_DEPTH) ? COL_W'($urandom_range(space, TABLE_DEPTH - 1)) : '0;
				end
				2: begin
					// duplicate of a stored column
					if (ld > 0) begin
						op  = $urandom_range(0, 1) ? OP_APPEND : OP_SWAP;
						col = syn_cover.columns[$urandom_range(0, ld - 1)];
						sl  = SLOT_W'($urandom_range(0, ld - 1));
					end
				end
				3: begin
					op = OP_SWAP;
					sl = SLOT_W'($urandom_range((ld < 255) ? ld : 255, 255));
					if (ld + 1 < space)
						col = fresh_column();
				end
				4: op = OP_UNKNOWN;
				default: ;
			endcase
		end
		send_item(op, sl, col);
	endtask

	task automatic random_phase(input int unsigned n, input int unsigned clear_pct);
		for (int unsigned i = 0; i < n; i++) begin
			if (i == n / 2)
				drain_results();
			random_item(clear_pct);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		opcode    = OP_CLEAR;
		slot      = '0;
		column    = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_REDUNDANCY;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset settings, space of 2048, 78 slots.
		send_item(OP_CLEAR, 8'd255, 12'd4095);
		send_item(OP_APPEND, 8'd0, 12'd0);
		send_item(OP_APPEND, 8'd0, 12'd2048);
		send_item(OP_APPEND, 8'd255, 12'd4095);
		send_item(OP_APPEND, 8'd0, 12'd1);
		send_item(OP_APPEND, 8'd0, 12'd2047);
		send_item(OP_APPEND, 8'd0, 12'd1);
		send_item(OP_APPEND, 8'd0, 12'd3);
		send_item(OP_APPEND, 8'd0, 12'd2);
		send_item(OP_APPEND, 8'd0, 12'd1024);
		send_item(OP_SWAP, 8'd0, 12'd1);
		send_item(OP_SWAP, 8'd0, 12'd5);
		send_item(OP_SWAP, 8'd255, 12'd6);
		send_item(OP_SWAP, 8'd5, 12'd7);
		send_item(OP_SWAP, 8'd4, 12'd0);
		send_item(OP_SWAP, 8'd1, 12'd2048);
		send_item(OP_UNKNOWN, 8'd0, 12'd9);
		send_item(OP_UNKNOWN, 8'd255, 12'd4095);
		send_item(OP_SWAP, 8'd1, 12'd1);
		send_item(OP_CLEAR, 8'd0, 12'd0);
		send_item(OP_APPEND, 8'd170, 12'd1365);
		write_reg(REG_COLUMN_TOTAL, 9'd3);
		send_item(OP_APPEND, 8'd85, 12'd682);
		send_item(OP_APPEND, 8'd0, 12'd4);
		send_item(OP_APPEND, 8'd0, 12'd8);
		// lower the limit under the loaded count: appends refused, swaps still taken
		write_reg(REG_COLUMN_TOTAL, 9'd1);
		send_item(OP_APPEND, 8'd0, 12'd16);
		send_item(OP_SWAP, 8'd2, 12'd16);

		// Full space and every slot: fill, then mostly swaps.
		set_space(12);
		write_reg(REG_COLUMN_TOTAL, 9'd256);
		while (syn_cover.n_loaded < syn_cover.capacity())
			send_item(OP_APPEND, SLOT_W'($urandom), fresh_column());
		random_phase(200, 1);

		set_space(3);
		write_reg(REG_COLUMN_TOTAL, 9'd3);
		random_phase(150, 3);

		set_space(0);
		write_reg(REG_COLUMN_TOTAL, 9'd0);
		random_phase(40, 3);

		set_space(15);
		write_reg(REG_COLUMN_TOTAL, 9'd511);
		random_phase(120, 1);
		write_reg(REG_COLUMN_TOTAL, 9'd5);
		random_phase(30, 0);

		for (int k = 0; k < 4; k++) begin
			set_space($urandom_range(4, 10));
			write_reg(REG_COLUMN_TOTAL, CFG_DATA_W'($urandom_range(3, 40)));
			calm = (k == 1);
			random_phase(100, 2);
			calm = 1'b0;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (syn_cover.mismatches == 0 && syn_cover.due.size() == 0)
			$display("pair_syndrome_cover_counter_unit test passed");
		else
			$display("pair_syndrome_cover_counter_unit test failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("pair_syndrome_cover_counter_unit test failed");
		$finish;
	end

endmodule

// File: filelist.f
hdl/psc_pkg.sv
hdl/psc_ram.sv
hdl/psc_update.sv
hdl/pair_syndrome_cover_counter_unit.sv
hdl/psc_checker.sv
sim/pair_syndrome_cover_counter_unit_tb.sv
